FILE: rtl/twc_pkg.sv
package twc_pkg;

  localparam int MAX_DEPTH_DEF = 16;

  typedef enum logic [3:0] {
    PH_FIELD,
    PH_FID,
    PH_SSTART,
    PH_BOOLB,
    PH_I8,
    PH_ZZ,
    PH_DBL,
    PH_BLEN,
    PH_BDATA,
    PH_LHDR,
    PH_LCNT,
    PH_MSIZE,
    PH_MTYPES,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    LV_STRUCT,
    LV_LIST,
    LV_MAP
  } lv_kind_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_WR_STRUCT,
    OP_WR_CONT,
    OP_LAST_ID,
    OP_ADVANCE
  } cell_op_t;

  typedef struct packed {
    lv_kind_t    kind;
    logic [15:0] last_id;
    logic [31:0] remaining;
    logic [3:0]  ktype;
    logic [3:0]  vtype;
    logic        toggle;
  } level_t;

  typedef struct packed {
    cell_op_t op;
    level_t   data;
  } cell_cmd_t;

  localparam logic [3:0] EV_FIELD_HDR   = 4'd0;
  localparam logic [3:0] EV_STRUCT_STOP = 4'd1;
  localparam logic [3:0] EV_INTEGER     = 4'd2;
  localparam logic [3:0] EV_BOOL        = 4'd3;
  localparam logic [3:0] EV_DOUBLE      = 4'd4;
  localparam logic [3:0] EV_BIN_LEN     = 4'd5;
  localparam logic [3:0] EV_BIN_BYTE    = 4'd6;
  localparam logic [3:0] EV_CONTAINER   = 4'd7;
  localparam logic [3:0] EV_END         = 4'd8;
  localparam logic [3:0] EV_ERROR       = 4'd9;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TRUNCATED = 3'd1;
  localparam logic [2:0] ERR_DEPTH     = 3'd2;
  localparam logic [2:0] ERR_VARINT    = 3'd3;
  localparam logic [2:0] ERR_LENGTH    = 3'd4;
  localparam logic [2:0] ERR_BAD_TYPE  = 3'd5;

  localparam logic [3:0] T_BOOL_TRUE  = 4'd1;
  localparam logic [3:0] T_BOOL_FALSE = 4'd2;
  localparam logic [3:0] T_BYTE       = 4'd3;
  localparam logic [3:0] T_I16        = 4'd4;
  localparam logic [3:0] T_I32        = 4'd5;
  localparam logic [3:0] T_I64        = 4'd6;
  localparam logic [3:0] T_DOUBLE     = 4'd7;
  localparam logic [3:0] T_BINARY     = 4'd8;
  localparam logic [3:0] T_LIST       = 4'd9;
  localparam logic [3:0] T_SET        = 4'd10;
  localparam logic [3:0] T_MAP        = 4'd11;
  localparam logic [3:0] T_STRUCT     = 4'd12;

  localparam logic [3:0] HDR_LONG_COUNT = 4'hF;
  localparam logic [3:0] VARINT_MAX     = 4'd10;

  localparam logic REG_DEPTH_LIMIT  = 1'b0;
  localparam logic REG_LENGTH_LIMIT = 1'b1;

  function automatic logic type_ok(input logic [3:0] t);
    return (t >= T_BOOL_TRUE) && (t <= T_STRUCT);
  endfunction

  function automatic logic [31:0] zz32(input logic [63:0] u);
    return (u[31:0] >> 1) ^ {32{u[0]}};
  endfunction

  function automatic logic [63:0] zz64(input logic [63:0] u);
    return (u >> 1) ^ {64{u[0]}};
  endfunction

endpackage

FILE: rtl/thrift_compact_stream_walker.sv
// Compact-protocol stream walker.
// The input channel takes one buffer byte per transfer, with in_last_byte marking
// the final byte; the root of every buffer is a struct. The result channel gives
// at most one event per input byte, in input order: field headers, struct stops,
// integers, booleans, doubles, binary lengths and bytes, container headers, the
// end of the root struct, or an error. Bytes that cause no event give no transfer.
// An event appears on the output register in the cycle after its byte is taken;
// one byte is taken every cycle while in_stall is low. The nesting stack is a row of
// level cells whose finished-container search ripples combinationally through the row.
// When the output register holds an event that the receiver stalls, in_stall is
// raised in the same cycle and the pending event is held until it is taken.
// Reset empties the output register, returns the parse to the root struct and sets
// depth_limit to 16 and length_limit to all ones. After an error or the end of the
// root struct, bytes are dropped up to in_last_byte, where the parse restarts. The user
// writes the two limits via the APB-style port while idle; the block does not check.
module thrift_compact_stream_walker #(
  parameter int MAX_DEPTH = twc_pkg::MAX_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_event_kind,
  output logic [4:0]         out_nest_depth,
  output logic signed [15:0] out_field_id,
  output logic [3:0]         out_field_type,
  output logic signed [63:0] out_value,
  output logic [3:0]         out_elem_type,
  output logic [3:0]         out_map_value_type,
  output logic [31:0]        out_item_count,
  output logic [2:0]         out_error_code,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import twc_pkg::*;

  localparam int LW = $clog2(MAX_DEPTH);

  logic [4:0]    dlim_r;
  logic [31:0]   llim_r;
  logic [LW-1:0] lvl_r, lvl_a, lvl_nxt;
  phase_t        phase_r, phase_a, phase_nxt;
  logic [63:0]   acc_r, acc_a, acc_nxt;
  logic [3:0]    vcnt_r, vcnt_a, vcnt_nxt;
  logic [31:0]   bleft_r, bleft_a, bleft_nxt;
  logic [7:0]    held_r, held_a, held_nxt;
  logic          err_r, err_a, err_nxt;

  logic          ev_v_a, ev_v;
  logic [3:0]    ev_kind_a, ev_kind;
  logic [LW-1:0] ev_depth_a, ev_depth;
  logic [15:0]   ev_fid_a, ev_fid;
  logic [3:0]    ev_ftype_a, ev_ftype;
  logic [63:0]   ev_value_a, ev_value;
  logic [3:0]    ev_et_a, ev_et;
  logic [3:0]    ev_vt_a, ev_vt;
  logic [31:0]   ev_cnt_a, ev_cnt;
  logic [2:0]    ev_code_a, ev_code;

  cell_cmd_t     cmd_a, cmd_nxt;
  logic [LW-1:0] cmd_idx_a, cmd_idx_nxt;
  logic          ed_en;
  logic [LW-1:0] ed_src;
  logic          sv_en_a;
  logic [3:0]    sv_t_a;

  level_t        cur_lv, tgt_lv;
  logic [LW-1:0] tgt_idx;

  logic          accept;
  logic [LW-1:0] lvl_p1;
  logic [6:0]    lim7;
  logic          can_push;
  logic [6:0]    vsh;
  logic [63:0]   vacc;
  logic [3:0]    vcnt_inc;
  logic          verr, vdone;
  logic [3:0]    dk;
  logic [5:0]    dsh;

  logic          out_valid_r;
  logic [3:0]    o_kind_r, o_ftype_r, o_et_r, o_vt_r;
  logic [4:0]    o_depth_r;
  logic [15:0]   o_fid_r;
  logic [63:0]   o_value_r;
  logic [31:0]   o_cnt_r;
  logic [2:0]    o_code_r;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_DEPTH_LIMIT) ? {27'd0, dlim_r} : llim_r;
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dlim_r <= 5'd16;
      llim_r <= 32'hFFFF_FFFF;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_DEPTH_LIMIT) begin
        dlim_r <= pwdata[4:0];
      end else begin
        llim_r <= pwdata;
      end
    end
  end

  twc_stack #(.MAX_DEPTH(MAX_DEPTH), .LW(LW)) u_stack (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (accept ? cmd_nxt : cell_cmd_t'('0)),
    .cmd_idx(cmd_idx_nxt),
    .rd_idx (lvl_r),
    .src_idx(ed_src),
    .rd_lv  (cur_lv),
    .tgt_idx(tgt_idx),
    .tgt_lv (tgt_lv)
  );

  assign lvl_p1 = lvl_r + LW'(1);

  always_comb begin
    lim7 = 7'(dlim_r);
    if (dlim_r == 5'd0) begin
      lim7 = 7'd1;
    end else if (7'(dlim_r) > 7'(MAX_DEPTH)) begin
      lim7 = 7'(MAX_DEPTH);
    end
  end
  assign can_push = (7'(lvl_r) + 7'd1) < lim7;

  assign vsh      = 7'(vcnt_r) * 7'd7;
  assign vacc     = (vcnt_r < VARINT_MAX) ? (acc_r | ({57'd0, in_data_byte[6:0]} << vsh)) : acc_r;
  assign vcnt_inc = vcnt_r + 4'd1;
  assign verr     = in_data_byte[7] && (vcnt_inc >= VARINT_MAX);
  assign vdone    = !in_data_byte[7];
  assign dk       = 4'd8 - bleft_r[3:0];
  assign dsh      = {dk[2:0], 3'b000};

  // Byte decode up to, but not including, the unwinding of finished containers.
  always_comb begin
    logic [3:0]    t, d;
    logic [LW-1:0] eff;
    logic [15:0]   lid;
    logic          df_en, fd_en, op_en, e_en;
    logic [15:0]   fd_id;
    logic [3:0]    fd_t;
    logic [LW-1:0] fd_lvl;
    logic [3:0]    op_ct, op_et, op_vt;
    logic [63:0]   op_cnt;
    logic [2:0]    e_code;
    logic [LW-1:0] e_depth;
    logic [31:0]   z;

    t = in_data_byte[3:0];
    d = in_data_byte[7:4];
    eff = lvl_r; lid = cur_lv.last_id;
    df_en = 1'b0; fd_en = 1'b0; op_en = 1'b0; e_en = 1'b0;
    fd_id = '0; fd_t = '0; fd_lvl = lvl_r;
    op_ct = '0; op_et = '0; op_vt = '0; op_cnt = '0;
    e_code = ERR_NONE; e_depth = lvl_r;
    z = zz32(vacc);

    lvl_a = lvl_r; phase_a = phase_r; acc_a = acc_r; vcnt_a = vcnt_r;
    bleft_a = bleft_r; held_a = held_r; err_a = err_r;
    ev_v_a = 1'b0; ev_kind_a = '0; ev_depth_a = lvl_r; ev_fid_a = '0; ev_ftype_a = '0;
    ev_value_a = '0; ev_et_a = '0; ev_vt_a = '0; ev_cnt_a = '0; ev_code_a = ERR_NONE;
    cmd_a = '0; cmd_idx_a = lvl_r;
    ed_en = 1'b0; ed_src = lvl_r;
    sv_en_a = 1'b0; sv_t_a = '0;

    if (!err_r && phase_r != PH_DONE) begin
      unique case (phase_r)
        PH_FIELD: df_en = 1'b1;
        PH_SSTART: begin
          if (!can_push) begin
            e_en = 1'b1; e_code = ERR_DEPTH;
          end else begin
            cmd_a.op = OP_WR_STRUCT;
            cmd_idx_a = lvl_p1;
            lvl_a = lvl_p1;
            eff = lvl_p1;
            lid = '0;
            df_en = 1'b1;
          end
        end
        PH_FID: begin
          acc_a = vacc; vcnt_a = vcnt_inc;
          if (verr) begin
            e_en = 1'b1; e_code = ERR_VARINT;
          end else if (vdone) begin
            fd_en = 1'b1; fd_id = z[15:0]; fd_t = held_r[3:0];
          end
        end
        PH_BOOLB: begin
          ev_v_a = 1'b1; ev_kind_a = EV_BOOL; ev_ftype_a = T_BOOL_TRUE;
          ev_value_a = {63'd0, in_data_byte == 8'd1};
          ed_en = 1'b1;
        end
        PH_I8: begin
          ev_v_a = 1'b1; ev_kind_a = EV_INTEGER; ev_ftype_a = T_BYTE;
          ev_value_a = {{56{in_data_byte[7]}}, in_data_byte};
          ed_en = 1'b1;
        end
        PH_ZZ: begin
          acc_a = vacc; vcnt_a = vcnt_inc;
          if (verr) begin
            e_en = 1'b1; e_code = ERR_VARINT;
          end else if (vdone) begin
            ev_v_a = 1'b1; ev_kind_a = EV_INTEGER; ev_ftype_a = held_r[3:0];
            if (held_r[3:0] == T_I64) begin
              ev_value_a = zz64(vacc);
            end else if (held_r[3:0] == T_I16) begin
              ev_value_a = {{48{z[15]}}, z[15:0]};
            end else begin
              ev_value_a = {{32{z[31]}}, z};
            end
            ed_en = 1'b1;
          end
        end
        PH_DBL: begin
          acc_a = acc_r | ({56'd0, in_data_byte} << dsh);
          bleft_a = bleft_r - 32'd1;
          if (bleft_a == 32'd0) begin
            ev_v_a = 1'b1; ev_kind_a = EV_DOUBLE; ev_ftype_a = T_DOUBLE;
            ev_value_a = acc_a;
            ed_en = 1'b1;
          end
        end
        PH_BLEN: begin
          acc_a = vacc; vcnt_a = vcnt_inc;
          if (verr) begin
            e_en = 1'b1; e_code = ERR_VARINT;
          end else if (vdone) begin
            if (vacc > {32'd0, llim_r}) begin
              e_en = 1'b1; e_code = ERR_LENGTH;
            end else begin
              ev_v_a = 1'b1; ev_kind_a = EV_BIN_LEN; ev_ftype_a = T_BINARY;
              ev_cnt_a = vacc[31:0];
              if (vacc == 64'd0) begin
                ed_en = 1'b1;
              end else begin
                bleft_a = vacc[31:0];
                phase_a = PH_BDATA;
              end
            end
          end
        end
        PH_BDATA: begin
          ev_v_a = 1'b1; ev_kind_a = EV_BIN_BYTE; ev_ftype_a = T_BINARY;
          ev_value_a = {56'd0, in_data_byte};
          bleft_a = bleft_r - 32'd1;
          if (bleft_a == 32'd0) begin
            ed_en = 1'b1;
          end
        end
        PH_LHDR: begin
          if (!type_ok(t)) begin
            e_en = 1'b1; e_code = ERR_BAD_TYPE;
          end else if (d == HDR_LONG_COUNT) begin
            held_a = {held_r[7:4], t};
            acc_a = '0; vcnt_a = '0;
            phase_a = PH_LCNT;
          end else begin
            op_en = 1'b1; op_ct = held_r[7:4]; op_et = t; op_cnt = {60'd0, d};
          end
        end
        PH_LCNT: begin
          acc_a = vacc; vcnt_a = vcnt_inc;
          if (verr) begin
            e_en = 1'b1; e_code = ERR_VARINT;
          end else if (vdone) begin
            op_en = 1'b1; op_ct = held_r[7:4]; op_et = held_r[3:0]; op_cnt = vacc;
          end
        end
        PH_MSIZE: begin
          acc_a = vacc; vcnt_a = vcnt_inc;
          if (verr) begin
            e_en = 1'b1; e_code = ERR_VARINT;
          end else if (vdone) begin
            if (vacc > {32'd0, llim_r}) begin
              e_en = 1'b1; e_code = ERR_LENGTH;
            end else if (vacc == 64'd0) begin
              op_en = 1'b1; op_ct = T_MAP;
            end else begin
              bleft_a = vacc[31:0];
              phase_a = PH_MTYPES;
            end
          end
        end
        PH_MTYPES: begin
          if (!type_ok(d) || !type_ok(t)) begin
            e_en = 1'b1; e_code = ERR_BAD_TYPE;
          end else begin
            op_en = 1'b1; op_ct = T_MAP; op_et = d; op_vt = t; op_cnt = {32'd0, bleft_r};
          end
        end
        default: ;
      endcase

      if (df_en) begin
        if (in_data_byte == 8'd0) begin
          if (eff == '0) begin
            ev_v_a = 1'b1; ev_kind_a = EV_END; ev_depth_a = eff;
            phase_a = PH_DONE;
          end else begin
            ev_v_a = 1'b1; ev_kind_a = EV_STRUCT_STOP; ev_depth_a = eff;
            ed_en = 1'b1; ed_src = eff - LW'(1);
          end
        end else if (!type_ok(t)) begin
          e_en = 1'b1; e_code = ERR_BAD_TYPE; e_depth = eff;
        end else if (d != 4'd0) begin
          fd_en = 1'b1; fd_id = lid + {12'd0, d}; fd_t = t; fd_lvl = eff;
        end else begin
          held_a = {4'd0, t};
          acc_a = '0; vcnt_a = '0;
          phase_a = PH_FID;
        end
      end

      if (fd_en) begin
        if (cmd_a.op == OP_WR_STRUCT) begin
          cmd_a.data.last_id = fd_id;
        end else begin
          cmd_a.op = OP_LAST_ID;
          cmd_idx_a = fd_lvl;
          cmd_a.data.last_id = fd_id;
        end
        ev_v_a = 1'b1; ev_kind_a = EV_FIELD_HDR; ev_depth_a = fd_lvl;
        ev_fid_a = fd_id; ev_ftype_a = fd_t;
        if (fd_t == T_BOOL_TRUE || fd_t == T_BOOL_FALSE) begin
          ev_value_a = {63'd0, fd_t == T_BOOL_TRUE};
          phase_a = PH_FIELD;
        end else begin
          sv_en_a = 1'b1; sv_t_a = fd_t;
        end
      end

      if (op_en) begin
        if (op_cnt > {32'd0, llim_r}) begin
          e_en = 1'b1; e_code = ERR_LENGTH;
        end else if (!can_push) begin
          e_en = 1'b1; e_code = ERR_DEPTH;
        end else begin
          ev_v_a = 1'b1; ev_kind_a = EV_CONTAINER; ev_depth_a = lvl_r;
          ev_ftype_a = op_ct; ev_et_a = op_et; ev_vt_a = op_vt; ev_cnt_a = op_cnt[31:0];
          if (op_cnt == 64'd0) begin
            ed_en = 1'b1;
          end else begin
            cmd_a.op = OP_WR_CONT;
            cmd_idx_a = lvl_p1;
            cmd_a.data.kind = (op_ct == T_MAP) ? LV_MAP : LV_LIST;
            cmd_a.data.last_id = '0;
            cmd_a.data.remaining = op_cnt[31:0];
            cmd_a.data.ktype = op_et;
            cmd_a.data.vtype = op_vt;
            cmd_a.data.toggle = 1'b0;
            lvl_a = lvl_p1;
            sv_en_a = 1'b1; sv_t_a = op_et;
          end
        end
      end

      if (e_en) begin
        ev_v_a = 1'b1; ev_kind_a = EV_ERROR; ev_depth_a = e_depth; ev_fid_a = '0;
        ev_ftype_a = '0; ev_value_a = '0; ev_et_a = '0; ev_vt_a = '0; ev_cnt_a = '0;
        ev_code_a = e_code;
        err_a = 1'b1;
      end
    end
  end

  // Unwinding of finished containers, start of the next value, and buffer restart.
  always_comb begin
    logic       sv_en;
    logic [3:0] sv_t;

    lvl_nxt = lvl_a; phase_nxt = phase_a; acc_nxt = acc_a; vcnt_nxt = vcnt_a;
    bleft_nxt = bleft_a; held_nxt = held_a; err_nxt = err_a;
    cmd_nxt = cmd_a; cmd_idx_nxt = cmd_idx_a;
    sv_en = sv_en_a; sv_t = sv_t_a;
    ev_v = ev_v_a; ev_kind = ev_kind_a; ev_depth = ev_depth_a; ev_fid = ev_fid_a;
    ev_ftype = ev_ftype_a; ev_value = ev_value_a; ev_et = ev_et_a; ev_vt = ev_vt_a;
    ev_cnt = ev_cnt_a; ev_code = ev_code_a;

    if (ed_en) begin
      lvl_nxt = tgt_idx;
      if (tgt_lv.kind == LV_STRUCT) begin
        phase_nxt = PH_FIELD;
      end else begin
        cmd_nxt = '0;
        cmd_nxt.op = OP_ADVANCE;
        cmd_idx_nxt = tgt_idx;
        sv_en = 1'b1;
        sv_t = (tgt_lv.kind == LV_MAP && !tgt_lv.toggle) ? tgt_lv.vtype : tgt_lv.ktype;
      end
    end

    if (sv_en) begin
      acc_nxt = '0;
      vcnt_nxt = '0;
      held_nxt = {4'd0, sv_t};
      unique case (sv_t)
        T_BOOL_TRUE, T_BOOL_FALSE: phase_nxt = PH_BOOLB;
        T_BYTE: phase_nxt = PH_I8;
        T_I16, T_I32, T_I64: phase_nxt = PH_ZZ;
        T_DOUBLE: begin
          bleft_nxt = 32'd8;
          phase_nxt = PH_DBL;
        end
        T_BINARY: phase_nxt = PH_BLEN;
        T_LIST, T_SET: begin
          held_nxt = {sv_t, 4'd0};
          phase_nxt = PH_LHDR;
        end
        T_MAP: phase_nxt = PH_MSIZE;
        default: phase_nxt = PH_SSTART;
      endcase
    end

    if (in_last_byte) begin
      if (!err_r && !err_nxt && phase_nxt != PH_DONE) begin
        ev_v = 1'b1; ev_kind = EV_ERROR; ev_depth = lvl_nxt; ev_fid = '0; ev_ftype = '0;
        ev_value = '0; ev_et = '0; ev_vt = '0; ev_cnt = '0; ev_code = ERR_TRUNCATED;
      end
      lvl_nxt = '0; phase_nxt = PH_FIELD; acc_nxt = '0; vcnt_nxt = '0;
      bleft_nxt = '0; held_nxt = '0; err_nxt = 1'b0;
      cmd_nxt = '0;
      cmd_nxt.op = OP_WR_STRUCT;
      cmd_idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r   <= '0;
      phase_r <= PH_FIELD;
      acc_r   <= '0;
      vcnt_r  <= '0;
      bleft_r <= '0;
      held_r  <= '0;
      err_r   <= 1'b0;
    end else if (accept) begin
      lvl_r   <= lvl_nxt;
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      vcnt_r  <= vcnt_nxt;
      bleft_r <= bleft_nxt;
      held_r  <= held_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= ev_v;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ev_v) begin
      o_kind_r  <= ev_kind;
      o_depth_r <= 5'(ev_depth);
      o_fid_r   <= ev_fid;
      o_ftype_r <= ev_ftype;
      o_value_r <= ev_value;
      o_et_r    <= ev_et;
      o_vt_r    <= ev_vt;
      o_cnt_r   <= ev_cnt;
      o_code_r  <= ev_code;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_kind     = o_kind_r;
  assign out_nest_depth     = o_depth_r;
  assign out_field_id       = o_fid_r;
  assign out_field_type     = o_ftype_r;
  assign out_value          = o_value_r;
  assign out_elem_type      = o_et_r;
  assign out_map_value_type = o_vt_r;
  assign out_item_count     = o_cnt_r;
  assign out_error_code     = o_code_r;

endmodule

FILE: rtl/twc_cell.sv
module twc_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               hit,
  input  twc_pkg::cell_cmd_t cmd,
  input  logic               start,
  input  logic               act_in,
  output logic               act_out,
  output logic               is_tgt,
  output twc_pkg::level_t    lv
);
  import twc_pkg::*;

  level_t lv_r;
  level_t lv_nxt;
  logic   pass;
  logic   active;

  always_comb begin
    lv_nxt = lv_r;
    if (hit) begin
      unique case (cmd.op)
        OP_WR_STRUCT, OP_WR_CONT: lv_nxt = cmd.data;
        OP_LAST_ID: lv_nxt.last_id = cmd.data.last_id;
        OP_ADVANCE: begin
          if (lv_r.kind == LV_MAP && !lv_r.toggle) begin
            lv_nxt.toggle = 1'b1;
          end else begin
            lv_nxt.toggle    = 1'b0;
            lv_nxt.remaining = lv_r.remaining - 32'd1;
          end
        end
        default: lv_nxt = lv_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r <= '0;
    end else begin
      lv_r <= lv_nxt;
    end
  end

  // A level is finished by the current element when it is a container on its last entry.
  assign pass    = (lv_r.kind != LV_STRUCT) && !(lv_r.kind == LV_MAP && !lv_r.toggle) &&
                   (lv_r.remaining == 32'd1);
  assign active  = start | act_in;
  assign act_out = active & pass;
  assign is_tgt  = active & ~pass;
  assign lv      = lv_r;

endmodule

FILE: rtl/twc_stack.sv
module twc_stack #(
  parameter int MAX_DEPTH = twc_pkg::MAX_DEPTH_DEF,
  parameter int LW        = $clog2(MAX_DEPTH)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  twc_pkg::cell_cmd_t cmd,
  input  logic [LW-1:0]      cmd_idx,
  input  logic [LW-1:0]      rd_idx,
  input  logic [LW-1:0]      src_idx,
  output twc_pkg::level_t    rd_lv,
  output logic [LW-1:0]      tgt_idx,
  output twc_pkg::level_t    tgt_lv
);
  import twc_pkg::*;

  level_t             lvs [MAX_DEPTH];
  logic [MAX_DEPTH:0] act;
  logic [MAX_DEPTH-1:0] tgt;

  assign act[MAX_DEPTH] = 1'b0;

  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    twc_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .hit    (cmd_idx == LW'(i)),
      .cmd    (cmd),
      .start  (src_idx == LW'(i)),
      .act_in (act[i+1]),
      .act_out(act[i]),
      .is_tgt (tgt[i]),
      .lv     (lvs[i])
    );
  end

  assign rd_lv = lvs[rd_idx];

  always_comb begin
    tgt_idx = '0;
    tgt_lv  = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (tgt[i]) begin
        tgt_idx = tgt_idx | LW'(i);
        tgt_lv  = tgt_lv | lvs[i];
      end
    end
  end

endmodule

FILE: rtl/twc_checker.sv
module twc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_event_kind,
  input logic [2:0] out_error_code
);
  import twc_pkg::*;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled while the output register is empty");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !in_valid) |=> !out_valid)
    else $error("event repeated after its transfer");

  a_code_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_event_kind == EV_ERROR) == (out_error_code != ERR_NONE)))
    else $error("error code does not match event kind");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_event_kind)))
    else $error("stalled event changed");

endmodule

bind thrift_compact_stream_walker twc_checker u_twc_checker (.*);
